// ===== design/sss_pkg.sv =====
// Package: opcodes, glyph tables and shared types for the seven-segment scan shifter.
`timescale 1ns / 1ps

package sss_pkg;

    localparam int unsigned NUM_DIGITS = 4;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned VALUE_W    = 14;
    localparam int unsigned ADDR_W     = 2;

    localparam logic [VALUE_W-1:0] MAX_SHOWN = 14'd9999;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SHOW  = 2'd1;
    localparam logic [1:0] OP_ELEC  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [7:0] BLANK_GLYPH = 8'hFF;

    typedef struct packed {
        logic                  en;
        logic [ADDR_W-1:0]     addr;
        logic [WORD_W-1:0]     data;
    } t_wr_req;

    // active-low segment patterns for 0..9; anything else is blank
    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        unique case (d)
            4'd0:    g = 8'hC0;
            4'd1:    g = 8'hF9;
            4'd2:    g = 8'hA4;
            4'd3:    g = 8'hB0;
            4'd4:    g = 8'h99;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h82;
            4'd7:    g = 8'hF8;
            4'd8:    g = 8'h80;
            4'd9:    g = 8'h90;
            default: g = BLANK_GLYPH;
        endcase
        return g;
    endfunction

    // "ELEC" by digit position
    function automatic logic [7:0] elec_glyph(input logic [ADDR_W-1:0] pos);
        logic [7:0] g;
        unique case (pos)
            2'd0:    g = 8'h86;
            2'd1:    g = 8'hC7;
            2'd2:    g = 8'h86;
            default: g = 8'hC6;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] digit_select(input logic [ADDR_W-1:0] pos);
        logic [7:0] s;
        unique case (pos)
            2'd0:    s = 8'hF1;
            2'd1:    s = 8'hF2;
            2'd2:    s = 8'hF4;
            default: s = 8'hF8;
        endcase
        return s;
    endfunction

    // decimal weight of each position, thousands first
    function automatic logic [VALUE_W-1:0] place_value(input logic [ADDR_W-1:0] pos);
        logic [VALUE_W-1:0] p;
        unique case (pos)
            2'd0:    p = 14'd1000;
            2'd1:    p = 14'd100;
            2'd2:    p = 14'd10;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== design/sss_disp_mem.sv =====
// Display word memory: four 16-bit words, one write port, one registered read port.
`timescale 1ns / 1ps

module sss_disp_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sss_pkg::t_wr_req            i_wr,
    input  logic                        i_rd_en,
    input  logic [sss_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [sss_pkg::WORD_W-1:0]  o_rd_data
);
    import sss_pkg::*;

    logic [WORD_W-1:0]     r_mem [NUM_DIGITS];
    logic [NUM_DIGITS-1:0] r_valid;
    logic [WORD_W-1:0]     r_rd_data;

    // entries not yet written read as the reset value (zero)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/sss_cmd_seq.sv =====
// Command sequencer: turns a display command into four word writes, one digit per cycle.
`timescale 1ns / 1ps

module sss_cmd_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_op,
    input  logic [sss_pkg::VALUE_W-1:0] i_value,
    output logic                        o_busy,
    output sss_pkg::t_wr_req            o_wr
);
    import sss_pkg::*;

    typedef enum logic [1:0] {
        CS_IDLE  = 2'b01,
        CS_WRITE = 2'b10
    } t_cmd_state;

    t_cmd_state         r_state, n_state;
    logic [ADDR_W-1:0]  r_step,  n_step;
    logic [1:0]         r_op;
    logic [VALUE_W-1:0] r_val,   n_val;

    logic [3:0]         digit;
    logic [VALUE_W-1:0] weight;
    logic [7:0]         pattern;

    // digit of the current position by a compare ladder against its multiples
    always_comb begin
        weight = place_value(r_step);
        digit  = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r_val >= VALUE_W'(k) * weight) begin
                digit = 4'(k);
            end
        end
    end

    always_comb begin
        unique case (r_op)
            OP_SHOW: pattern = digit_glyph(digit);
            OP_ELEC: pattern = elec_glyph(r_step);
            default: pattern = BLANK_GLYPH;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_val   = r_val;
        unique case (r_state)
            CS_IDLE: begin
                if (i_start) begin
                    n_state = CS_WRITE;
                    n_step  = '0;
                    n_val   = (i_value > MAX_SHOWN) ? MAX_SHOWN : i_value;
                end
            end
            CS_WRITE: begin
                n_step = r_step + 1'b1;
                n_val  = r_val - VALUE_W'(digit) * weight;
                if (r_step == ADDR_W'(NUM_DIGITS - 1)) begin
                    n_state = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_start && r_state == CS_IDLE) begin
            r_op <= i_op;
        end
    end

    assign o_busy    = (r_state == CS_WRITE);
    assign o_wr.en   = (r_state == CS_WRITE);
    assign o_wr.addr = r_step;
    assign o_wr.data = {pattern, digit_select(r_step)};

endmodule

// ===== design/sss_shifter.sv =====
// Serializer: shifts a 16-bit display word out MSB first, flags the last bit.
`timescale 1ns / 1ps

module sss_shifter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [sss_pkg::WORD_W-1:0]  i_word,
    output logic                        o_can_load,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_bit,
    output logic                        o_last
);
    import sss_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic              r_active;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_shift;
    logic              last_bit;
    logic              beat;

    assign last_bit   = (r_cnt == CNT_W'(WORD_W - 1));
    assign beat       = r_active && i_ready;
    // next word may enter as the last bit of the current one leaves
    assign o_can_load = !r_active || (beat && last_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_load) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (beat) begin
            r_cnt <= r_cnt + 1'b1;
            if (last_bit) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift <= i_word;
        end else if (beat) begin
            r_shift <= {r_shift[WORD_W-2:0], 1'b0};
        end
    end

    assign o_valid = r_active;
    assign o_bit   = r_shift[WORD_W-1];
    assign o_last  = last_bit;

endmodule

// ===== design/seven_segment_scan_shifter.sv =====
// Top level: seven-segment scan shifter with stream input and serial bit output.
`timescale 1ns / 1ps

// Drives a four-digit common-anode display through an external 16-bit shift
// register. Input words carry an opcode in tuser (scan tick, show number, show
// ELEC, clear) and a number in tdata; numbers above 9999 show as 9999. A scan
// tick yields sixteen output words, one per cycle while the output is ready, MSB
// first: segment byte then digit-select byte, tlast on the sixteenth (pulse the
// storage clock after it), and moves to the next digit. The next tick is taken
// while the current word is still shifting, so the serializer paces the ticks.
// A display command makes four writes on the display memory's single write
// port (one digit per cycle); input is held off during those writes and while a
// fetched word waits for the serializer. Before any command, zeros are shifted.
module seven_segment_scan_shifter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [13:0] number_value, [15:14] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] serial_bit, [7:1] zero
    output logic        o_m_axis_tlast    // latch_strobe
);
    import sss_pkg::*;

    logic              cmd_busy;
    t_wr_req           wr_req;
    logic              in_word;
    logic              tick_acc;
    logic              cmd_acc;
    logic [ADDR_W-1:0] r_scan_digit;
    logic              r_rd_pend;
    logic [WORD_W-1:0] rd_data;
    logic              sh_can_load;
    logic              sh_load;
    logic              ser_bit;

    assign o_s_axis_tready = !cmd_busy && !r_rd_pend;
    assign in_word  = i_s_axis_tvalid && o_s_axis_tready;
    assign tick_acc = in_word && (i_s_axis_tuser == OP_TICK);
    assign cmd_acc  = in_word && (i_s_axis_tuser != OP_TICK);
    assign sh_load  = r_rd_pend && sh_can_load;

    sss_cmd_seq u_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmd_acc),
        .i_op    (i_s_axis_tuser),
        .i_value (i_s_axis_tdata[VALUE_W-1:0]),
        .o_busy  (cmd_busy),
        .o_wr    (wr_req)
    );

    sss_disp_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_req),
        .i_rd_en   (tick_acc),
        .i_rd_addr (r_scan_digit),
        .o_rd_data (rd_data)
    );

    // memory output register doubles as the holding slot for the next word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_digit <= '0;
            r_rd_pend    <= 1'b0;
        end else begin
            if (tick_acc) begin
                r_scan_digit <= r_scan_digit + 1'b1;
            end
            if (tick_acc) begin
                r_rd_pend <= 1'b1;
            end else if (sh_load) begin
                r_rd_pend <= 1'b0;
            end
        end
    end

    sss_shifter u_shift (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (sh_load),
        .i_word     (rd_data),
        .o_can_load (sh_can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_bit      (ser_bit),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'd0, ser_bit};

    // a command never writes the display memory while a fetched word is pending
    a_no_write_during_fetch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> !r_rd_pend)
        else $error("display write overlaps a pending word fetch");

    // a fetched word stays pending until the serializer takes it
    a_pend_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && !sh_load) |=> r_rd_pend)
        else $error("fetched display word dropped");

    // each tick advances the digit pointer by exactly one
    a_digit_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> (r_scan_digit == $past(r_scan_digit) + 2'd1))
        else $error("digit pointer did not advance on scan tick");

    // a new word only enters an idle serializer or one finishing its last bit
    a_load_safe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sh_load |-> (!o_m_axis_tvalid || (o_m_axis_tlast && i_m_axis_tready)))
        else $error("serializer reloaded mid-word");

endmodule
